### src/ctcp_stream_dequote_deframer_defines.svh
// assertion macros for the ctcp stream dequote deframer checker
`ifndef CTCP_STREAM_DEQUOTE_DEFRAMER_DEFINES_SVH
`define CTCP_STREAM_DEQUOTE_DEFRAMER_DEFINES_SVH

// clocked assertion, off while reset is high
`define CSDD_ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// clocked assertion that also holds across reset
`define CSDD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/csdd_pkg.sv
// shared types and byte codes of the ctcp stream dequote deframer
`timescale 1ns / 1ps

package csdd_pkg;

   localparam logic [7:0] BYTE_XDELIM = 8'h01;
   localparam logic [7:0] BYTE_MQUOTE = 8'h10;
   localparam logic [7:0] BYTE_XQUOTE = 8'h5C;
   localparam logic [7:0] BYTE_SPACE  = 8'h20;
   localparam logic [7:0] BYTE_NUL    = 8'h00;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_DIGIT0 = 8'h30;
   localparam logic [7:0] BYTE_LOW_A  = 8'h61;
   localparam logic [7:0] BYTE_LOW_N  = 8'h6E;
   localparam logic [7:0] BYTE_LOW_R  = 8'h72;
   localparam logic [7:0] BYTE_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_CMD   = 2'd1;
   localparam logic [1:0] KIND_PARAM = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_word_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic [1:0] seg_kind;
      logic       seg_end;
      logic       msg_end;
      logic       last_of_run;
   } rsp_word_type;

   // work handed from front to back: up to two dequoted bytes and the end flag
   typedef struct packed {
      logic       has_bytes;
      logic       two_bytes;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       last;
   } task_type;

endpackage

### src/ctcp_stream_dequote_deframer.sv
// top level of the ctcp stream dequote deframer
`timescale 1ns / 1ps

// Takes one message byte per word and returns decoded results, one per cycle
// while the receiver is ready. The front stage undoes low-level quoting and
// accepts a byte every cycle while the work queue has room; the back stage emits
// at most one result word per cycle, handling in turn each dequoted byte, each
// backslash it flushes literally and the message end, so one byte causes up to
// four results. Results pass through a hold register and an output register.
// The queue between the stages (QUEUE_DEPTH entries, at least 2) absorbs those
// bursts.

module ctcp_stream_dequote_deframer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  csdd_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output csdd_pkg::rsp_word_type rsp_data
);
   import csdd_pkg::*;

   logic     push_valid;
   logic     push_ready;
   task_type push_task;
   logic     q_valid;
   logic     q_pop;
   task_type q_task;

   csdd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_task  (push_task),
      .push_ready (push_ready)
   );

   csdd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_task  (push_task),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_task   (q_task)
   );

   csdd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_task    (q_task),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### src/csdd_front.sv
// front stage: accepts raw bytes and undoes low-level quoting
`timescale 1ns / 1ps

module csdd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csdd_pkg::req_word_type req_data,
   output logic                  push_valid,
   output csdd_pkg::task_type    push_task,
   input  logic                  push_ready
);
   import csdd_pkg::*;

   logic     low_pend_ff;
   logic     low_pend_in;
   logic     accept;
   task_type work;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      work           = '0;
      work.last      = req_data.in_last;
      work.byte0     = req_data.in_byte;
      work.has_bytes = 1'b1;
      low_pend_in    = low_pend_ff;
      if (low_pend_ff) begin
         low_pend_in = 1'b0;
         if (req_data.in_byte == BYTE_DIGIT0) begin
            work.byte0 = BYTE_NUL;
         end else if (req_data.in_byte == BYTE_LOW_N) begin
            work.byte0 = BYTE_LF;
         end else if (req_data.in_byte == BYTE_LOW_R) begin
            work.byte0 = BYTE_CR;
         end else if (req_data.in_byte == BYTE_MQUOTE) begin
            work.byte0 = BYTE_MQUOTE;
         end else begin
            // unknown escape: literal quote byte, then the byte itself
            work.byte0     = BYTE_MQUOTE;
            work.byte1     = req_data.in_byte;
            work.two_bytes = 1'b1;
         end
      end else if (req_data.in_byte == BYTE_MQUOTE && !req_data.in_last) begin
         low_pend_in    = 1'b1;
         work.has_bytes = 1'b0;
      end
      if (req_data.in_last) begin
         low_pend_in = 1'b0;
      end
   end

   assign push_valid = req_valid && (work.has_bytes || work.last);
   assign push_task  = work;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_pend_ff <= 1'b0;
      end else if (accept) begin
         low_pend_ff <= low_pend_in;
      end
   end

endmodule

### src/csdd_queue.sv
// short queue of dequoted work between the front and back stages
`timescale 1ns / 1ps

module csdd_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  csdd_pkg::task_type push_task,
   output logic               pop_valid,
   input  logic               pop,
   output csdd_pkg::task_type pop_task
);
   import csdd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   task_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_task   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_task;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### src/csdd_back.sv
// back stage: ctcp deframing, one result per cycle into a hold and output register unless the output stalls
`timescale 1ns / 1ps

module csdd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  csdd_pkg::task_type     q_task,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output csdd_pkg::rsp_word_type rsp_data
);
   import csdd_pkg::*;

   typedef enum logic [1:0] {
      PH_BYTE0,
      PH_BYTE1,
      PH_END
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic         inside_ff, inside_in;
   logic         esc_ff, esc_in;
   logic         param_ff, param_in;
   logic         text_ff, text_in;
   logic         hold_valid_ff, hold_valid_in;
   rsp_word_type hold_ff, hold_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;

   logic         out_free;
   logic         fire;
   logic         is_end;
   logic [7:0]   sym;
   logic [1:0]   unit_kind;
   logic         produce;
   logic         step_end;
   logic         cd_req;
   logic [7:0]   cd_byte;
   rsp_word_type new_word;
   rsp_word_type push_word;
   logic         push_hold;

   function automatic rsp_word_type data_word(input logic [7:0] b, input logic [1:0] k);
      rsp_word_type w;
      w          = '0;
      w.has_byte = 1'b1;
      w.out_byte = b;
      w.seg_kind = k;
      return w;
   endfunction

   function automatic rsp_word_type marker_word(input logic [1:0] k);
      rsp_word_type w;
      w          = '0;
      w.seg_kind = k;
      w.seg_end  = 1'b1;
      return w;
   endfunction

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = q_valid && out_free;
   assign is_end    = (phase_ff == PH_END) || !q_task.has_bytes;
   assign sym       = (phase_ff == PH_BYTE1) ? q_task.byte1 : q_task.byte0;
   assign unit_kind = param_ff ? KIND_PARAM : KIND_CMD;

   always_comb begin
      phase_in  = phase_ff;
      inside_in = inside_ff;
      esc_in    = esc_ff;
      param_in  = param_ff;
      text_in   = text_ff;
      produce   = 1'b0;
      step_end  = 1'b0;
      cd_req    = 1'b0;
      cd_byte   = sym;
      new_word  = '0;
      if (fire) begin
         if (inside_ff && esc_ff &&
             (is_end || (sym != BYTE_LOW_A && sym != BYTE_XQUOTE))) begin
            // pending backslash flushed literally, symbol stays in place and is handled after it
            esc_in   = 1'b0;
            produce  = 1'b1;
            new_word = data_word(BYTE_XQUOTE, unit_kind);
         end else if (is_end) begin
            if (inside_ff) begin
               produce  = 1'b1;
               new_word = marker_word(unit_kind);
            end else if (text_ff) begin
               produce  = 1'b1;
               new_word = marker_word(KIND_TEXT);
            end
            inside_in = 1'b0;
            esc_in    = 1'b0;
            param_in  = 1'b0;
            text_in   = 1'b0;
            step_end  = 1'b1;
         end else begin
            if (!inside_ff) begin
               if (sym == BYTE_XDELIM) begin
                  if (text_ff) begin
                     produce  = 1'b1;
                     new_word = marker_word(KIND_TEXT);
                  end
                  text_in   = 1'b0;
                  inside_in = 1'b1;
                  param_in  = 1'b0;
                  esc_in    = 1'b0;
               end else begin
                  produce  = 1'b1;
                  new_word = data_word(sym, KIND_TEXT);
                  text_in  = 1'b1;
               end
            end else if (esc_ff) begin
               esc_in  = 1'b0;
               cd_req  = 1'b1;
               cd_byte = (sym == BYTE_LOW_A) ? BYTE_XDELIM : BYTE_XQUOTE;
            end else if (sym == BYTE_XDELIM) begin
               produce   = 1'b1;
               new_word  = marker_word(unit_kind);
               inside_in = 1'b0;
               param_in  = 1'b0;
            end else if (sym == BYTE_XQUOTE) begin
               esc_in = 1'b1;
            end else begin
               cd_req = 1'b1;
            end
            if (cd_req) begin
               if (param_ff) begin
                  produce  = 1'b1;
                  new_word = data_word(cd_byte, KIND_PARAM);
               end else if (cd_byte == BYTE_SPACE) begin
                  // first space splits command from parameter and is dropped
                  param_in = 1'b1;
               end else begin
                  produce = 1'b1;
                  if (cd_byte >= BYTE_LOW_A && cd_byte <= BYTE_LOW_Z) begin
                     new_word = data_word(cd_byte - CASE_OFFSET, KIND_CMD);
                  end else begin
                     new_word = data_word(cd_byte, KIND_CMD);
                  end
               end
            end
            if (phase_ff == PH_BYTE0 && q_task.two_bytes) begin
               phase_in = PH_BYTE1;
            end else if (q_task.last) begin
               phase_in = PH_END;
            end else begin
               step_end = 1'b1;
            end
         end
         if (step_end) begin
            phase_in = PH_BYTE0;
         end
         if (step_end && produce) begin
            new_word.last_of_run = 1'b1;
            new_word.msg_end     = q_task.last;
         end
      end
   end

   assign pop = fire && step_end;

   // a held word is released once it is known whether it ends its run
   assign push_hold = out_free && hold_valid_ff &&
                      (hold_ff.last_of_run || (fire && (produce || step_end)));

   always_comb begin
      push_word = hold_ff;
      // only a held word of the current byte takes the end-of-run flags
      if (fire && step_end && !produce && !hold_ff.last_of_run) begin
         push_word.last_of_run = 1'b1;
         push_word.msg_end     = q_task.last;
      end
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (fire && produce) begin
         hold_valid_in = 1'b1;
         hold_in       = new_word;
      end else if (push_hold) begin
         hold_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (push_hold) begin
         out_valid_in = 1'b1;
         out_in       = push_word;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_BYTE0;
         inside_ff     <= 1'b0;
         esc_ff        <= 1'b0;
         param_ff      <= 1'b0;
         text_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         inside_ff     <= inside_in;
         esc_ff        <= esc_in;
         param_ff      <= param_in;
         text_ff       <= text_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### src/csdd_port_checker.sv
// port-level checks for the ctcp stream dequote deframer and their bind
`timescale 1ns / 1ps
`include "ctcp_stream_dequote_deframer_defines.svh"

module csdd_port_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input csdd_pkg::rsp_word_type rsp_data
);
   import csdd_pkg::*;

   `CSDD_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "rsp valid after reset")

   `CSDD_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp word changed while stalled")

   `CSDD_ASSERT_CLK(a_marker_xor_data, rsp_valid |-> rsp_data.has_byte != rsp_data.seg_end, "word is both or neither data and marker")

   `CSDD_ASSERT_CLK(a_marker_zero, rsp_valid && !rsp_data.has_byte |-> rsp_data.out_byte == BYTE_NUL, "marker carries a byte")

   `CSDD_ASSERT_CLK(a_msg_end_run, rsp_valid && rsp_data.msg_end |-> rsp_data.last_of_run, "message end not at end of run")

endmodule

bind ctcp_stream_dequote_deframer csdd_port_checker u_port_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/testbench.sv
// self-checking testbench of the ctcp stream dequote deframer
`timescale 1ns / 1ps

module testbench;
   import csdd_pkg::*;

   localparam int MAX_WORDS_PER_BYTE = 4;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PRINT_CAP = 40;
   localparam int RANDOM_BYTES = 115;
   localparam int NOISE_BYTES = 40;
   localparam int HOLD_OFF_LEN = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid;
   logic req_ready;
   req_word_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_word_type rsp_data;

   // decoder state mirrored from the block
   logic low_esc_pending = 1'b0;
   logic in_ctcp = 1'b0;
   logic ctcp_esc_pending = 1'b0;
   logic param_open = 1'b0;
   logic text_open = 1'b0;

   rsp_word_type run_words[$];
   rsp_word_type decoded_words_due[$];
   logic [7:0] msg_buf[$];

   int error_count = 0;
   int words_seen = 0;
   int bytes_sent = 0;
   int cycle_count = 0;
   int hold_off_cycles = 0;
   bit req_gaps_on = 0;
   bit rsp_stalls_on = 0;

   ctcp_stream_dequote_deframer DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ctcp_stream_dequote_deframer: mismatch");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic void put_word(logic has, logic [7:0] b, logic [1:0] kind, logic closing);
      rsp_word_type w;
      if (run_words.size() >= MAX_WORDS_PER_BYTE) return;
      w = '0;
      w.has_byte = has;
      w.out_byte = has ? b : 8'h00;
      w.seg_kind = kind;
      w.seg_end = closing;
      run_words.push_back(w);
   endfunction

   function automatic void ctcp_byte(logic [7:0] d);
      if (!param_open) begin
         // first space splits command from parameter and is dropped
         if (d == BYTE_SPACE) begin
            param_open = 1'b1;
            return;
         end
         if (d >= BYTE_LOW_A && d <= BYTE_LOW_Z) d = d - CASE_OFFSET;
         put_word(1'b1, d, KIND_CMD, 1'b0);
      end else begin
         put_word(1'b1, d, KIND_PARAM, 1'b0);
      end
   endfunction

   function automatic void close_ctcp();
      if (ctcp_esc_pending) begin
         ctcp_esc_pending = 1'b0;
         ctcp_byte(BYTE_XQUOTE);
      end
      put_word(1'b0, BYTE_NUL, param_open ? KIND_PARAM : KIND_CMD, 1'b1);
      in_ctcp = 1'b0;
      param_open = 1'b0;
   endfunction

   function automatic void deframe_byte(logic [7:0] d);
      if (!in_ctcp) begin
         if (d == BYTE_XDELIM) begin
            if (text_open) put_word(1'b0, BYTE_NUL, KIND_TEXT, 1'b1);
            text_open = 1'b0;
            in_ctcp = 1'b1;
            param_open = 1'b0;
            ctcp_esc_pending = 1'b0;
         end else begin
            put_word(1'b1, d, KIND_TEXT, 1'b0);
            text_open = 1'b1;
         end
         return;
      end
      if (ctcp_esc_pending) begin
         ctcp_esc_pending = 1'b0;
         if (d == BYTE_LOW_A) begin
            ctcp_byte(BYTE_XDELIM);
            return;
         end
         if (d == BYTE_XQUOTE) begin
            ctcp_byte(BYTE_XQUOTE);
            return;
         end
         ctcp_byte(BYTE_XQUOTE);
      end
      if (d == BYTE_XDELIM) close_ctcp();
      else if (d == BYTE_XQUOTE) ctcp_esc_pending = 1'b1;
      else ctcp_byte(d);
   endfunction

   function automatic void decode_word(req_word_type w);
      logic [7:0] b;
      rsp_word_type tail;
      b = w.in_byte;
      run_words.delete();
      if (low_esc_pending) begin
         low_esc_pending = 1'b0;
         case (b)
            BYTE_DIGIT0: deframe_byte(BYTE_NUL);
            BYTE_LOW_N:  deframe_byte(BYTE_LF);
            BYTE_LOW_R:  deframe_byte(BYTE_CR);
            BYTE_MQUOTE: deframe_byte(BYTE_MQUOTE);
            default: begin
               deframe_byte(BYTE_MQUOTE);
               deframe_byte(b);
            end
         endcase
      end else if (b == BYTE_MQUOTE && !w.in_last) begin
         low_esc_pending = 1'b1;
      end else begin
         deframe_byte(b);
      end
      if (w.in_last) begin
         if (in_ctcp) close_ctcp();
         else if (text_open) put_word(1'b0, BYTE_NUL, KIND_TEXT, 1'b1);
         low_esc_pending = 1'b0;
         in_ctcp = 1'b0;
         ctcp_esc_pending = 1'b0;
         param_open = 1'b0;
         text_open = 1'b0;
      end
      if (run_words.size() > 0) begin
         tail = run_words.pop_back();
         tail.last_of_run = 1'b1;
         tail.msg_end = w.in_last;
         run_words.push_back(tail);
      end
      foreach (run_words[i]) decoded_words_due.push_back(run_words[i]);
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < PRINT_CAP)
         $display("error at word %0d: %s got %0h expected %0h", words_seen, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_words_due.size() == 0) begin
            report_mismatch("word with none due", int'(rsp_data), 0);
         end else begin
            want = decoded_words_due.pop_front();
            if (rsp_data.has_byte !== want.has_byte)
               report_mismatch("has_byte", int'(rsp_data.has_byte), int'(want.has_byte));
            if (rsp_data.out_byte !== want.out_byte)
               report_mismatch("out_byte", int'(rsp_data.out_byte), int'(want.out_byte));
            if (rsp_data.seg_kind !== want.seg_kind)
               report_mismatch("seg_kind", int'(rsp_data.seg_kind), int'(want.seg_kind));
            if (rsp_data.seg_end !== want.seg_end)
               report_mismatch("seg_end", int'(rsp_data.seg_end), int'(want.seg_end));
            if (rsp_data.msg_end !== want.msg_end)
               report_mismatch("msg_end", int'(rsp_data.msg_end), int'(want.msg_end));
            if (rsp_data.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", int'(rsp_data.last_of_run),
                               int'(want.last_of_run));
         end
         words_seen++;
      end
   end

   // ---------------- driving ----------------

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver: random stalls, plus a long hold-off when asked
   initial begin : receiver
      int n;
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            n = hold_off_cycles;
            repeat (n) @(posedge clock);
            hold_off_cycles = 0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = pick_gap() + 1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      req_word_type w;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.in_byte = b;
      w.in_last = last;
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      decode_word(w);
      bytes_sent++;
   endtask

   task automatic send_message();
      foreach (msg_buf[i]) send_word(msg_buf[i], i == msg_buf.size() - 1);
   endtask

   task automatic wait_drained();
      while (decoded_words_due.size() != 0) @(posedge clock);
   endtask

   // ---------------- message building ----------------

   function automatic void add_ctcp_unit();
      int n;
      msg_buf.push_back(BYTE_XDELIM);
      n = $urandom_range(0, 4);
      repeat (n) msg_buf.push_back(8'($urandom_range(8'h41, 8'h7A)));
      if ($urandom_range(0, 3) != 0) begin
         msg_buf.push_back(BYTE_SPACE);
         n = $urandom_range(0, 5);
         repeat (n) begin
            case ($urandom_range(0, 5))
               0: begin
                  msg_buf.push_back(BYTE_XQUOTE);
                  case ($urandom_range(0, 2))
                     0: msg_buf.push_back(BYTE_LOW_A);
                     1: msg_buf.push_back(BYTE_XQUOTE);
                     default: msg_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
                  endcase
               end
               1: msg_buf.push_back(BYTE_SPACE);
               default: msg_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            endcase
         end
      end
      // a quarter of the units run to end of message and an eighth hit an escape at the close
      case ($urandom_range(0, 7))
         0, 1: ;
         2: begin
            msg_buf.push_back(BYTE_XQUOTE);
            msg_buf.push_back(BYTE_XDELIM);
         end
         default: msg_buf.push_back(BYTE_XDELIM);
      endcase
   endfunction

   function automatic void build_message();
      int pieces;
      msg_buf.delete();
      pieces = $urandom_range(1, 4);
      repeat (pieces) begin
         case ($urandom_range(0, 9))
            0, 1, 2: msg_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            3: begin
               msg_buf.push_back(BYTE_MQUOTE);
               case ($urandom_range(0, 4))
                  0: msg_buf.push_back(BYTE_DIGIT0);
                  1: msg_buf.push_back(BYTE_LOW_N);
                  2: msg_buf.push_back(BYTE_LOW_R);
                  3: msg_buf.push_back(BYTE_MQUOTE);
                  default: msg_buf.push_back(8'($urandom_range(0, 255)));
               endcase
            end
            4, 5, 6: add_ctcp_unit();
            7: msg_buf.push_back(8'($urandom_range(0, 255)));
            8: msg_buf.push_back(BYTE_XQUOTE);
            default: msg_buf.push_back(BYTE_XDELIM);
         endcase
      end
   endfunction

   // ---------------- tests ----------------

   task automatic test_directed();
      req_gaps_on = 0;
      rsp_stalls_on = 0;
      // low-level escapes, an unknown one, and one on the final byte
      msg_buf = '{BYTE_MQUOTE, BYTE_DIGIT0, BYTE_MQUOTE, BYTE_LOW_N, BYTE_MQUOTE, BYTE_LOW_R,
                  BYTE_MQUOTE, BYTE_MQUOTE, BYTE_MQUOTE, 8'h78, BYTE_MQUOTE};
      send_message();
      // ctcp unit with case edges, quoted delimiter, quoted backslash, unknown escape,
      // escape left at the delimiter, then an empty unit
      msg_buf = '{8'h48, BYTE_XDELIM, BYTE_LOW_A, BYTE_LOW_Z, 8'h60, 8'h7B, BYTE_SPACE,
                  BYTE_XQUOTE, BYTE_LOW_A, BYTE_XQUOTE, BYTE_XQUOTE, BYTE_XQUOTE, 8'h71,
                  BYTE_SPACE, BYTE_XQUOTE, BYTE_XDELIM, BYTE_XDELIM, BYTE_XDELIM};
      send_message();
      // unterminated unit with an escape pending at the end
      msg_buf = '{8'h78, BYTE_XDELIM, 8'h76, BYTE_XQUOTE};
      send_message();
      // extreme bytes, and a lone delimiter as a whole message
      msg_buf = '{8'hFF, 8'h00};
      send_message();
      msg_buf = '{BYTE_XDELIM};
      send_message();
   endtask

   task automatic test_random_messages();
      int goal;
      req_gaps_on = 1;
      rsp_stalls_on = 1;
      goal = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < goal) begin
         build_message();
         send_message();
         // short stretches with no idling at all
         if ($urandom_range(0, 9) == 0) begin
            req_gaps_on = ~req_gaps_on;
            rsp_stalls_on = ~rsp_stalls_on;
         end
      end
      req_gaps_on = 1;
      rsp_stalls_on = 1;
   endtask

   task automatic test_noise();
      repeat (NOISE_BYTES)
         send_word(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      // close whatever message the noise left open
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic test_backpressure();
      req_gaps_on = 0;
      hold_off_cycles = HOLD_OFF_LEN;
      // unknown escapes give two words per byte pair, so the queue fills quickly
      repeat (6) begin
         msg_buf = '{8'h41, BYTE_MQUOTE, 8'h7E, BYTE_XDELIM, BYTE_LOW_A, BYTE_XQUOTE};
         send_message();
      end
      req_gaps_on = 1;
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_messages();
      test_backpressure();
      test_noise();

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && decoded_words_due.size() == 0) begin
         $display("ctcp_stream_dequote_deframer: match");
      end else begin
         $display("ctcp_stream_dequote_deframer: mismatch");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/csdd_pkg.sv
src/csdd_front.sv
src/csdd_queue.sv
src/csdd_back.sv
src/ctcp_stream_dequote_deframer.sv
src/csdd_port_checker.sv
tb/testbench.sv
